>>> hdl/eq_breakpoint_bin_interpolator_defines.svh
// Assertion macros shared by the equalizer breakpoint interpolator.
// Included by the front and back modules; depends on nothing else.
`ifndef EQ_BREAKPOINT_BIN_INTERPOLATOR_DEFINES_SVH
`define EQ_BREAKPOINT_BIN_INTERPOLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EBI_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EBI_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ebi_pkg.sv
// Shared types and constants of the equalizer breakpoint interpolator.
// Used by every module of the block except ebi_ram; depends on nothing.
package ebi_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = PTR_W + 1;
  localparam int FREQ_W     = 24;
  localparam int GAIN_W     = 16;
  localparam int GAINS_W    = 4 * GAIN_W;
  localparam int BIN_W      = 14;
  localparam int PROD_W     = FREQ_W + BIN_W;
  localparam int MSB_W      = $clog2(PROD_W);
  localparam int MANT_W     = 31;
  localparam int MANT_FRAC  = 30;
  localparam int FRAC_W     = 16;
  localparam int FCNT_W     = $clog2(FRAC_W);
  localparam int LOG_W      = MSB_W + FRAC_W;
  localparam int LG_W       = 26;
  localparam int T_W        = FRAC_W + 1;
  localparam int BL_W       = LG_W + T_W + 1;
  localparam int CODE_W     = GAIN_W - 1;
  localparam int BITP_W     = $clog2(CODE_W);
  localparam int DCNT_W     = $clog2(T_W);
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int FILL_W     = $clog2(Q_DEPTH + 1);
  localparam int CFG_W      = FREQ_W;

  localparam logic signed [LG_W-1:0] NEG_FLOOR_LOG2 = -26'sd10098862;
  localparam logic [21:0] BIN_WIDTH_RESET = 22'd22050;

  localparam logic REG_BIN_WIDTH   = 1'b0;
  localparam logic REG_INTERP_MODE = 1'b1;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_ORDER = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    status_t            status;
    logic [CNT_W-1:0]   n;
    logic [FREQ_W-1:0]  freq;
    logic [GAINS_W-1:0] gains;
    logic [BIN_W-1:0]   bin;
  } qent_t;

  typedef enum logic [4:0] {
    B_IDLE, B_WRITE, B_MUL, B_RADDR, B_RCMP, B_GEX, B_GEX2, B_GA, B_GB, B_GC,
    B_DIVS, B_DIVW, B_PART, B_PARTB, B_LOGS, B_LOGW, B_BSUB, B_BMUL, B_BADD,
    B_BEND, B_DONE
  } back_state_t;

  typedef enum logic [2:0] {
    TG_F1, TG_F2, TG_FF, TG_A, TG_B, TG_R
  } log_tag_t;

  typedef enum logic [1:0] {
    LG_IDLE, LG_MSB, LG_SHIFT, LG_SQ
  } log_state_t;

  typedef enum logic {
    DV_IDLE, DV_RUN
  } div_state_t;

endpackage

>>> hdl/ebi_ram.sv
// Generic single-write, single-read memory with registered read data.
// Used for the breakpoint tables; depends on nothing.
module ebi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ebi_log2.sv
// Iterative log2 unit giving a Q16 result, one squaring step per cycle.
// Depends on ebi_pkg.
module ebi_log2 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ebi_pkg::PROD_W-1:0] x,
  output logic                       done,
  output logic [ebi_pkg::LOG_W-1:0]  res
);

  ebi_pkg::log_state_t              state, state_next;
  logic [ebi_pkg::PROD_W-1:0]       xr;
  logic [ebi_pkg::MSB_W-1:0]        msb, msb_enc;
  logic [ebi_pkg::MANT_W-1:0]       m, mant;
  logic [ebi_pkg::FRAC_W-1:0]       frac;
  logic [ebi_pkg::FCNT_W-1:0]       cnt;
  logic [2*ebi_pkg::MANT_W-1:0]     sq;
  logic [ebi_pkg::MANT_W:0]         s;
  logic [ebi_pkg::PROD_W-1:0]       sh_r, sh_l;

  always_comb begin
    msb_enc = '0;
    for (int i = 0; i < ebi_pkg::PROD_W; i++) begin
      if (xr[i]) begin
        msb_enc = ebi_pkg::MSB_W'(i);
      end
    end
  end

  always_comb begin
    sh_r = xr >> (msb - ebi_pkg::MSB_W'(ebi_pkg::MANT_FRAC));
    sh_l = xr << (ebi_pkg::MSB_W'(ebi_pkg::MANT_FRAC) - msb);
    if (msb >= ebi_pkg::MSB_W'(ebi_pkg::MANT_FRAC)) begin
      mant = sh_r[ebi_pkg::MANT_W-1:0];
    end else begin
      mant = sh_l[ebi_pkg::MANT_W-1:0];
    end
    sq = (2*ebi_pkg::MANT_W)'(m) * (2*ebi_pkg::MANT_W)'(m);
    s  = sq[2*ebi_pkg::MANT_W-1:ebi_pkg::MANT_FRAC];
  end

  always_comb begin
    state_next = state;
    case (state)
      ebi_pkg::LG_IDLE: begin
        if (start) begin
          state_next = ebi_pkg::LG_MSB;
        end
      end
      ebi_pkg::LG_MSB:   state_next = ebi_pkg::LG_SHIFT;
      ebi_pkg::LG_SHIFT: state_next = ebi_pkg::LG_SQ;
      ebi_pkg::LG_SQ: begin
        if (cnt == '0) begin
          state_next = ebi_pkg::LG_IDLE;
        end
      end
      default: state_next = ebi_pkg::LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ebi_pkg::LG_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ebi_pkg::LG_SQ) && (cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ebi_pkg::LG_IDLE: begin
        if (start) begin
          xr <= (x == '0) ? ebi_pkg::PROD_W'(1) : x;
        end
      end
      ebi_pkg::LG_MSB: msb <= msb_enc;
      ebi_pkg::LG_SHIFT: begin
        m    <= mant;
        cnt  <= '1;
        frac <= '0;
      end
      ebi_pkg::LG_SQ: begin
        frac <= {frac[ebi_pkg::FRAC_W-2:0], s[ebi_pkg::MANT_W]};
        m    <= s[ebi_pkg::MANT_W] ? s[ebi_pkg::MANT_W:1] : s[ebi_pkg::MANT_W-1:0];
        cnt  <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  assign res = {msb, frac};

endmodule

>>> hdl/ebi_div.sv
// Restoring divider giving (num << 16) / den for num <= den, one bit per cycle.
// Depends on ebi_pkg.
module ebi_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ebi_pkg::FREQ_W-1:0] num,
  input  logic [ebi_pkg::FREQ_W-1:0] den,
  output logic                       done,
  output logic [ebi_pkg::T_W-1:0]    q
);

  ebi_pkg::div_state_t          state, state_next;
  logic [ebi_pkg::FREQ_W:0]     rem, diff, rem_keep;
  logic [ebi_pkg::FREQ_W-1:0]   dr;
  logic [ebi_pkg::DCNT_W-1:0]   cnt;
  logic                         ge;

  always_comb begin
    ge       = rem >= {1'b0, dr};
    diff     = rem - {1'b0, dr};
    rem_keep = ge ? diff : rem;
  end

  always_comb begin
    state_next = state;
    case (state)
      ebi_pkg::DV_IDLE: begin
        if (start) begin
          state_next = ebi_pkg::DV_RUN;
        end
      end
      ebi_pkg::DV_RUN: begin
        if (cnt == '0) begin
          state_next = ebi_pkg::DV_IDLE;
        end
      end
      default: state_next = ebi_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ebi_pkg::DV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ebi_pkg::DV_RUN) && (cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ebi_pkg::DV_IDLE: begin
        if (start) begin
          rem <= {1'b0, num};
          dr  <= den;
          cnt <= ebi_pkg::DCNT_W'(ebi_pkg::T_W - 1);
          q   <= '0;
        end
      end
      ebi_pkg::DV_RUN: begin
        q   <= {q[ebi_pkg::T_W-2:0], ge};
        rem <= {rem_keep[ebi_pkg::FREQ_W-1:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/ebi_front.sv
// Front end: accepts requests, checks them against the table shadow and queues them.
// Depends on ebi_pkg and the assertion macro header.
`include "eq_breakpoint_bin_interpolator_defines.svh"

module ebi_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  op,
  input  logic [ebi_pkg::FREQ_W-1:0]  point_freq,
  input  logic [ebi_pkg::GAINS_W-1:0] gains,
  input  logic [ebi_pkg::BIN_W-1:0]   bin_index,
  output logic                        q_empty,
  input  logic                        q_pop,
  output ebi_pkg::qent_t              q_head
);

  ebi_pkg::qent_t               ent_q [ebi_pkg::Q_DEPTH];
  logic [ebi_pkg::Q_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [ebi_pkg::FILL_W-1:0]   fill;
  logic [ebi_pkg::CNT_W-1:0]    count, count_next;
  logic [ebi_pkg::FREQ_W-1:0]   last_freq, last_freq_next;
  ebi_pkg::status_t             st;
  logic                         accept;
  ebi_pkg::qent_t               new_ent;

  assign full    = fill == ebi_pkg::FILL_W'(ebi_pkg::Q_DEPTH);
  assign q_empty = fill == '0;
  assign accept  = push && !full;
  assign q_head  = ent_q[rd_ptr];

  always_comb begin
    st             = ebi_pkg::ST_OK;
    count_next     = count;
    last_freq_next = last_freq;
    case (ebi_pkg::cmd_t'(op))
      ebi_pkg::CMD_CLEAR: count_next = '0;
      ebi_pkg::CMD_APPEND: begin
        if (count >= ebi_pkg::CNT_W'(ebi_pkg::MAX_POINTS)) begin
          st = ebi_pkg::ST_FULL;
        end else if (count != '0 && point_freq <= last_freq) begin
          st = ebi_pkg::ST_ORDER;
        end else begin
          count_next     = count + 1'b1;
          last_freq_next = point_freq;
        end
      end
      ebi_pkg::CMD_QUERY: begin
        if (count < ebi_pkg::CNT_W'(2)) begin
          st = ebi_pkg::ST_FEW;
        end
      end
      default: ;
    endcase
    new_ent.cmd    = ebi_pkg::cmd_t'(op);
    new_ent.status = st;
    new_ent.n      = count;
    new_ent.freq   = point_freq;
    new_ent.gains  = gains;
    new_ent.bin    = bin_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) begin
        count  <= count_next;
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop && !q_empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + ebi_pkg::FILL_W'(accept) - ebi_pkg::FILL_W'(q_pop && !q_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_q[wr_ptr] <= new_ent;
      last_freq     <= last_freq_next;
    end
  end

  `EBI_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= ebi_pkg::CNT_W'(ebi_pkg::MAX_POINTS), "point count above table size")
  `EBI_ASSERT_NEXT(a_clear_count, clk, rst, accept && op == ebi_pkg::CMD_CLEAR, count == '0, "clear did not empty the table")

endmodule

>>> hdl/ebi_back.sv
// Back end: executes queued requests against the breakpoint memories and interpolates.
// Depends on ebi_pkg, ebi_ram, ebi_log2, ebi_div and the assertion macro header.
`include "eq_breakpoint_bin_interpolator_defines.svh"

module ebi_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic                       wr_index,
  input  logic [ebi_pkg::CFG_W-1:0]  wr_data,
  input  logic                       q_empty,
  input  ebi_pkg::qent_t             q_head,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [15:0]         out_left_re,
  output logic signed [15:0]         out_left_im,
  output logic signed [15:0]         out_right_re,
  output logic signed [15:0]         out_right_im,
  output logic [1:0]                 status
);

  ebi_pkg::back_state_t                state, state_next;
  ebi_pkg::log_tag_t                   tag;
  ebi_pkg::qent_t                      ent;
  logic [ebi_pkg::FREQ_W-1:0]          bin_width;
  logic [1:0]                          interp_mode;
  logic [ebi_pkg::PROD_W-1:0]          f;
  logic [ebi_pkg::PTR_W-1:0]           j, last_idx;
  logic [ebi_pkg::FREQ_W-1:0]          p_prev, p_cur;
  logic [ebi_pkg::GAINS_W-1:0]         ga, gb, res;
  ebi_pkg::status_t                    res_status;
  logic [ebi_pkg::T_W-1:0]             t;
  logic [ebi_pkg::LOG_W-1:0]           l1, l2;
  logic signed [ebi_pkg::LG_W-1:0]     la, lb, diff, y;
  logic signed [ebi_pkg::BL_W-1:0]     prod, blend_sum, blend_q;
  logic [1:0]                          k;
  logic [ebi_pkg::CODE_W-1:0]          r, cand;
  logic [ebi_pkg::BITP_W-1:0]          bitpos;
  logic [ebi_pkg::FREQ_W-1:0]          dnum, dden;
  logic                                out_valid, out_load;
  logic [ebi_pkg::GAINS_W-1:0]         out_data;
  ebi_pkg::status_t                    out_st;

  logic                                f_we, g_we;
  logic [ebi_pkg::PTR_W-1:0]           g_raddr;
  logic [ebi_pkg::FREQ_W-1:0]          fram_rd;
  logic [ebi_pkg::GAINS_W-1:0]         gram_rd;
  logic                                log_start, log_done, div_start, div_done;
  logic [ebi_pkg::PROD_W-1:0]          log_x;
  logic [ebi_pkg::LOG_W-1:0]           log_res;
  logic [ebi_pkg::T_W-1:0]             div_q;

  logic                                db, hit, p_eq, no_div, log_le;
  logic signed [ebi_pkg::GAIN_W-1:0]   a_part, b_part;
  logic [ebi_pkg::LOG_W-1:0]           lf_diff, l_span;

  ebi_ram #(.WIDTH(ebi_pkg::FREQ_W), .DEPTH(ebi_pkg::MAX_POINTS)) u_freq_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (ent.n[ebi_pkg::PTR_W-1:0]),
    .wdata (ent.freq),
    .raddr (j),
    .rdata (fram_rd)
  );

  ebi_ram #(.WIDTH(ebi_pkg::GAINS_W), .DEPTH(ebi_pkg::MAX_POINTS)) u_gain_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (ent.n[ebi_pkg::PTR_W-1:0]),
    .wdata (ent.gains),
    .raddr (g_raddr),
    .rdata (gram_rd)
  );

  ebi_log2 u_log2 (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .x     (log_x),
    .done  (log_done),
    .res   (log_res)
  );

  ebi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dnum),
    .den   (dden),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    db        = interp_mode[1];
    last_idx  = ent.n[ebi_pkg::PTR_W-1:0] - 1'b1;
    hit       = ebi_pkg::PROD_W'(fram_rd) >= f;
    p_eq      = ebi_pkg::PROD_W'(fram_rd) == f;
    a_part    = $signed(ga[{k, 4'd0} +: ebi_pkg::GAIN_W]);
    b_part    = $signed(gb[{k, 4'd0} +: ebi_pkg::GAIN_W]);
    cand      = r | (ebi_pkg::CODE_W'(1) << bitpos);
    log_le    = $signed(ebi_pkg::LG_W'(log_res)) <= y;
    no_div    = (l2 <= l1) || (log_res <= l1);
    lf_diff   = log_res - l1;
    l_span    = l2 - l1;
    blend_sum = prod + ebi_pkg::BL_W'(32768);
    blend_q   = blend_sum >>> 16;
    case (tag)
      ebi_pkg::TG_F1: log_x = ebi_pkg::PROD_W'(p_prev);
      ebi_pkg::TG_F2: log_x = ebi_pkg::PROD_W'(p_cur);
      ebi_pkg::TG_A:  log_x = ebi_pkg::PROD_W'(a_part[ebi_pkg::CODE_W-1:0]);
      ebi_pkg::TG_B:  log_x = ebi_pkg::PROD_W'(b_part[ebi_pkg::CODE_W-1:0]);
      ebi_pkg::TG_R:  log_x = ebi_pkg::PROD_W'(cand);
      default:        log_x = f;
    endcase
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    log_start  = 1'b0;
    div_start  = 1'b0;
    f_we       = 1'b0;
    g_we       = 1'b0;
    g_raddr    = j;
    out_load   = 1'b0;
    case (state)
      ebi_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.status != ebi_pkg::ST_OK) begin
            state_next = ebi_pkg::B_DONE;
          end else begin
            case (q_head.cmd)
              ebi_pkg::CMD_APPEND: state_next = ebi_pkg::B_WRITE;
              ebi_pkg::CMD_QUERY:  state_next = ebi_pkg::B_MUL;
              default:             state_next = ebi_pkg::B_DONE;
            endcase
          end
        end
      end
      ebi_pkg::B_WRITE: begin
        f_we       = 1'b1;
        g_we       = 1'b1;
        state_next = ebi_pkg::B_DONE;
      end
      ebi_pkg::B_MUL:   state_next = ebi_pkg::B_RADDR;
      ebi_pkg::B_RADDR: state_next = ebi_pkg::B_RCMP;
      ebi_pkg::B_RCMP: begin
        if (hit) begin
          state_next = (j == '0 || p_eq) ? ebi_pkg::B_GEX : ebi_pkg::B_GA;
        end else if (j == last_idx) begin
          state_next = ebi_pkg::B_GEX;
        end else begin
          state_next = ebi_pkg::B_RADDR;
        end
      end
      ebi_pkg::B_GEX:  state_next = ebi_pkg::B_GEX2;
      ebi_pkg::B_GEX2: state_next = ebi_pkg::B_DONE;
      ebi_pkg::B_GA: begin
        g_raddr    = j - 1'b1;
        state_next = ebi_pkg::B_GB;
      end
      ebi_pkg::B_GB: state_next = ebi_pkg::B_GC;
      ebi_pkg::B_GC: begin
        state_next = interp_mode[0] ? ebi_pkg::B_LOGS : ebi_pkg::B_DIVS;
      end
      ebi_pkg::B_DIVS: begin
        div_start  = 1'b1;
        state_next = ebi_pkg::B_DIVW;
      end
      ebi_pkg::B_DIVW: begin
        if (div_done) begin
          state_next = ebi_pkg::B_PART;
        end
      end
      ebi_pkg::B_PART: begin
        if (!db) begin
          state_next = ebi_pkg::B_BSUB;
        end else if (a_part > 0) begin
          state_next = ebi_pkg::B_LOGS;
        end else begin
          state_next = ebi_pkg::B_PARTB;
        end
      end
      ebi_pkg::B_PARTB: begin
        state_next = (b_part > 0) ? ebi_pkg::B_LOGS : ebi_pkg::B_BSUB;
      end
      ebi_pkg::B_LOGS: begin
        log_start  = 1'b1;
        state_next = ebi_pkg::B_LOGW;
      end
      ebi_pkg::B_LOGW: begin
        if (log_done) begin
          case (tag)
            ebi_pkg::TG_F1, ebi_pkg::TG_F2: state_next = ebi_pkg::B_LOGS;
            ebi_pkg::TG_FF: state_next = no_div ? ebi_pkg::B_PART : ebi_pkg::B_DIVS;
            ebi_pkg::TG_A:  state_next = ebi_pkg::B_PARTB;
            ebi_pkg::TG_B:  state_next = ebi_pkg::B_BSUB;
            default: begin
              if (bitpos != '0) begin
                state_next = ebi_pkg::B_LOGS;
              end else begin
                state_next = (k == 2'd3) ? ebi_pkg::B_DONE : ebi_pkg::B_PART;
              end
            end
          endcase
        end
      end
      ebi_pkg::B_BSUB: state_next = ebi_pkg::B_BMUL;
      ebi_pkg::B_BMUL: state_next = ebi_pkg::B_BADD;
      ebi_pkg::B_BADD: state_next = ebi_pkg::B_BEND;
      ebi_pkg::B_BEND: begin
        if (db && y >= 0) begin
          state_next = ebi_pkg::B_LOGS;
        end else begin
          state_next = (k == 2'd3) ? ebi_pkg::B_DONE : ebi_pkg::B_PART;
        end
      end
      ebi_pkg::B_DONE: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = ebi_pkg::B_IDLE;
        end
      end
      default: state_next = ebi_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ebi_pkg::B_IDLE;
      out_valid   <= 1'b0;
      bin_width   <= ebi_pkg::FREQ_W'(ebi_pkg::BIN_WIDTH_RESET);
      interp_mode <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        case (wr_index)
          ebi_pkg::REG_BIN_WIDTH:   bin_width   <= wr_data;
          ebi_pkg::REG_INTERP_MODE: interp_mode <= wr_data[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
      out_st   <= res_status;
    end
    case (state)
      ebi_pkg::B_IDLE: begin
        if (!q_empty) begin
          ent        <= q_head;
          res        <= '0;
          res_status <= q_head.status;
        end
      end
      ebi_pkg::B_MUL: begin
        f <= ebi_pkg::PROD_W'(bin_width) * ebi_pkg::PROD_W'(ent.bin);
        j <= '0;
        k <= '0;
      end
      ebi_pkg::B_RCMP: begin
        p_cur <= fram_rd;
        if (!hit && j != last_idx) begin
          p_prev <= fram_rd;
          j      <= j + 1'b1;
        end
      end
      ebi_pkg::B_GEX2: res <= gram_rd;
      ebi_pkg::B_GB:   ga  <= gram_rd;
      ebi_pkg::B_GC: begin
        gb   <= gram_rd;
        tag  <= ebi_pkg::TG_F1;
        dnum <= f[ebi_pkg::FREQ_W-1:0] - p_prev;
        dden <= p_cur - p_prev;
      end
      ebi_pkg::B_DIVW: begin
        if (div_done) begin
          t <= div_q;
        end
      end
      ebi_pkg::B_PART: begin
        tag <= ebi_pkg::TG_A;
        if (!db) begin
          la <= ebi_pkg::LG_W'(a_part);
          lb <= ebi_pkg::LG_W'(b_part);
        end else if (!(a_part > 0)) begin
          la <= ebi_pkg::NEG_FLOOR_LOG2;
        end
      end
      ebi_pkg::B_PARTB: begin
        tag <= ebi_pkg::TG_B;
        if (!(b_part > 0)) begin
          lb <= ebi_pkg::NEG_FLOOR_LOG2;
        end
      end
      ebi_pkg::B_LOGW: begin
        if (log_done) begin
          case (tag)
            ebi_pkg::TG_F1: begin
              l1  <= log_res;
              tag <= ebi_pkg::TG_F2;
            end
            ebi_pkg::TG_F2: begin
              l2  <= log_res;
              tag <= ebi_pkg::TG_FF;
            end
            ebi_pkg::TG_FF: begin
              if (no_div) begin
                t <= '0;
              end
              dnum <= ebi_pkg::FREQ_W'(lf_diff);
              dden <= ebi_pkg::FREQ_W'(l_span);
            end
            ebi_pkg::TG_A: la <= ebi_pkg::LG_W'(log_res);
            ebi_pkg::TG_B: lb <= ebi_pkg::LG_W'(log_res);
            default: begin
              if (log_le) begin
                r <= cand;
              end
              if (bitpos == '0) begin
                res[{k, 4'd0} +: ebi_pkg::GAIN_W] <= {1'b0, (log_le ? cand : r)};
                k <= k + 1'b1;
              end else begin
                bitpos <= bitpos - 1'b1;
              end
            end
          endcase
        end
      end
      ebi_pkg::B_BSUB: diff <= lb - la;
      ebi_pkg::B_BMUL: prod <= diff * $signed({1'b0, t});
      ebi_pkg::B_BADD: y <= la + blend_q[ebi_pkg::LG_W-1:0];
      ebi_pkg::B_BEND: begin
        if (!db) begin
          res[{k, 4'd0} +: ebi_pkg::GAIN_W] <= y[ebi_pkg::GAIN_W-1:0];
          k <= k + 1'b1;
        end else if (y < 0) begin
          res[{k, 4'd0} +: ebi_pkg::GAIN_W] <= '0;
          k <= k + 1'b1;
        end else begin
          r      <= '0;
          bitpos <= ebi_pkg::BITP_W'(ebi_pkg::CODE_W - 1);
          tag    <= ebi_pkg::TG_R;
        end
      end
      default: ;
    endcase
  end

  assign empty        = !out_valid;
  assign out_left_re  = out_data[15:0];
  assign out_left_im  = out_data[31:16];
  assign out_right_re = out_data[47:32];
  assign out_right_im = out_data[63:48];
  assign status       = out_st;

  `EBI_ASSERT_NOW(a_log_done_waited, clk, rst, log_done, state == ebi_pkg::B_LOGW, "log2 result arrived while nobody waited")
  `EBI_ASSERT_NOW(a_div_done_waited, clk, rst, div_done, state == ebi_pkg::B_DIVW, "divider result arrived while nobody waited")

endmodule

>>> hdl/eq_breakpoint_bin_interpolator.sv
// Top level of the equalizer breakpoint table with per-bin gain interpolation.
// Depends on ebi_pkg, ebi_front and ebi_back.
//
// Channel    Handshake        Payload
// request    push / full      op, point_freq, in_left_re/im, in_right_re/im, bin_index
// result     empty / pop      out_left_re/im, out_right_re/im, status
// config     wr_en            wr_index, wr_data
//
// A four-entry queue between front and back end takes requests while a result waits.
// A query scans the breakpoints in order and, when it interpolates, normally divides
// for the blend weight. The log axis adds three log2 passes and the dB modes up to 17
// per gain part.
// Reset is synchronous and needs no clearing pass.
module eq_breakpoint_bin_interpolator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 op,
  input  logic [ebi_pkg::FREQ_W-1:0] point_freq,
  input  logic signed [15:0]         in_left_re,
  input  logic signed [15:0]         in_left_im,
  input  logic signed [15:0]         in_right_re,
  input  logic signed [15:0]         in_right_im,
  input  logic [ebi_pkg::BIN_W-1:0]  bin_index,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [15:0]         out_left_re,
  output logic signed [15:0]         out_left_im,
  output logic signed [15:0]         out_right_re,
  output logic signed [15:0]         out_right_im,
  output logic [1:0]                 status,
  input  logic                       wr_en,
  input  logic                       wr_index,
  input  logic [ebi_pkg::CFG_W-1:0]  wr_data
);

  logic                        q_empty, q_pop;
  ebi_pkg::qent_t              q_head;
  logic [ebi_pkg::GAINS_W-1:0] gains;

  assign gains = {in_right_im, in_right_re, in_left_im, in_left_re};

  ebi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .point_freq (point_freq),
    .gains      (gains),
    .bin_index  (bin_index),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_head     (q_head)
  );

  ebi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_left_re  (out_left_re),
    .out_left_im  (out_left_im),
    .out_right_re (out_right_re),
    .out_right_im (out_right_im),
    .status       (status)
  );

endmodule
